// ===== hw/rtl/tim_pkg.sv =====
`default_nettype none

package tim_pkg;

    // sizes of the stores
    localparam int MAX_COLS    = 8192;
    localparam int SCALE_SLOTS = 16;
    localparam int ACT_WORDS   = MAX_COLS / 4;
    localparam int ACT_AW      = $clog2(ACT_WORDS);
    localparam int SCALE_AW    = $clog2(SCALE_SLOTS);

    // field widths
    localparam int SLOT_W  = 11;
    localparam int ACT_W   = 8;
    localparam int WORD_W  = 4 * ACT_W;
    localparam int SCALE_W = 32;
    localparam int WTS_W   = 8;
    localparam int ROW_W   = 16;
    localparam int ACC_W   = 22;
    localparam int COL_W   = 12;
    localparam int PROD_W  = 53;
    localparam int MUL_W   = ACC_W + SCALE_W;
    localparam int CFG_W   = 14;
    localparam int GC_W    = 5;
    localparam int DIV_W   = CFG_W + SCALE_AW;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // register reset values
    localparam logic [CFG_W-1:0] RST_ROW_LENGTH  = CFG_W'(2560);
    localparam logic [CFG_W-1:0] RST_GROUP_ROWS  = CFG_W'(4096);
    localparam logic [GC_W-1:0]  RST_GROUP_COUNT = GC_W'(1);

    // register indexes
    localparam logic [1:0] CFG_ROW_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_GROUP_ROWS  = 2'd1;
    localparam logic [1:0] CFG_GROUP_COUNT = 2'd2;

    // item kinds
    typedef enum logic [1:0] {
        KIND_ACT    = 2'd0,
        KIND_SCALE  = 2'd1,
        KIND_WEIGHT = 2'd2
    } kind_t;

    // ternary weight codes
    localparam logic [1:0] CODE_ADD = 2'd1;
    localparam logic [1:0] CODE_SUB = 2'd2;

    // one finished row, waiting for its scale multiply
    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic signed [ACC_W-1:0]   sum;
        logic signed [SCALE_W-1:0] scale;
    } row_entry_t;

    typedef struct packed {
        logic       valid;
        row_entry_t entry;
    } push_t;

    // scale group of a row: min(row / gs, gc - 1), gc clamped to 1..SCALE_SLOTS,
    // quotient bits found by a short restoring division that saturates early
    function automatic logic [SCALE_AW-1:0] group_index(
        input logic [ROW_W-1:0] row,
        input logic [CFG_W-1:0] gs,
        input logic [GC_W-1:0]  gc
    );
        logic [DIV_W-1:0]    rem;
        logic [DIV_W-1:0]    thr;
        logic [SCALE_AW-1:0] q;
        logic [SCALE_AW-1:0] lim;
        if (gc == '0) begin
            lim = '0;
        end else if (gc > GC_W'(SCALE_SLOTS)) begin
            lim = SCALE_AW'(SCALE_SLOTS - 1);
        end else begin
            lim = SCALE_AW'(gc - 1'b1);
        end
        rem = DIV_W'(row);
        q   = '0;
        if (gs == '0) begin
            q = '0;
        end else if (rem >= (DIV_W'(gs) << SCALE_AW)) begin
            q = '1;
        end else begin
            for (int i = SCALE_AW - 1; i >= 0; i--) begin
                thr = DIV_W'(gs) << i;
                if (rem >= thr) begin
                    rem  = rem - thr;
                    q[i] = 1'b1;
                end
            end
        end
        return (q > lim) ? lim : q;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tim_ram.sv =====
`default_nettype none

module tim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tim_front.sv =====
`default_nettype none

module tim_front
    import tim_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_kind,
    input  wire logic [SLOT_W-1:0]         s_slot,
    input  wire logic [WORD_W-1:0]         s_acts,
    input  wire logic [SCALE_W-1:0]        s_scale_value,
    input  wire logic [WTS_W-1:0]          s_weights,
    input  wire logic [QCW-1:0]            q_level,
    output push_t                          push
);

    logic [CFG_W-1:0]   row_length_reg;
    logic [CFG_W-1:0]   rows_per_group_reg;
    logic [GC_W-1:0]    group_count_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [SCALE_AW-1:0] s1_gi_reg;
    logic [WTS_W-1:0]   s1_wts_reg;

    logic [SCALE_W-1:0] scale_reg [SCALE_SLOTS];

    logic               accept;
    logic               is_act;
    logic               is_scale;
    logic               is_wt;
    logic [COL_W-1:0]   bytes;
    logic [COL_W-1:0]   col_inc;
    logic               row_done;
    logic [WORD_W-1:0]  word;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [10:0] sum4;
    logic [QCW:0]       level_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg     <= RST_ROW_LENGTH;
            rows_per_group_reg <= RST_GROUP_ROWS;
            group_count_reg    <= RST_GROUP_COUNT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROW_LENGTH:  row_length_reg     <= cfg_wdata;
                CFG_GROUP_ROWS:  rows_per_group_reg <= cfg_wdata;
                CFG_GROUP_COUNT: group_count_reg    <= cfg_wdata[GC_W-1:0];
                default: ;
            endcase
        end
    end

    // accept only while the queue keeps room for the row in flight
    assign level_sum = (QCW+1)'(q_level) + (QCW+1)'(push.valid);
    assign s_ready   = level_sum < (QCW+1)'(QDEPTH);
    assign accept    = s_valid && s_ready;
    assign is_act    = accept && (s_kind == KIND_ACT);
    assign is_scale  = accept && (s_kind == KIND_SCALE);
    assign is_wt     = accept && (s_kind == KIND_WEIGHT);

    // column position and row end
    assign bytes    = row_length_reg[CFG_W-1:2];
    assign col_inc  = col_reg + 1'b1;
    assign row_done = col_inc >= bytes;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (is_act) begin
            col_next = '0;
            row_next = '0;
        end else if (is_wt) begin
            if (row_done) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_inc;
            end
        end
    end

    // activation store, read at the current column
    tim_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ACT_WORDS)
    ) u_act_ram (
        .aclk  (aclk),
        .we    (is_act),
        .waddr (s_slot[ACT_AW-1:0]),
        .wdata (s_acts),
        .raddr (col_reg[ACT_AW-1:0]),
        .rdata (word)
    );

    // scale store
    always_ff @(posedge aclk) begin
        if (is_scale && (s_slot < SLOT_W'(SCALE_SLOTS))) begin
            scale_reg[s_slot[SCALE_AW-1:0]] <= s_scale_value;
        end
    end

    // second stage: four ternary terms against the activation word
    always_comb begin
        logic signed [ACT_W-1:0] a;
        logic [1:0]              code;
        sum4 = '0;
        for (int k = 0; k < 4; k++) begin
            a    = word[k*ACT_W +: ACT_W];
            code = s1_wts_reg[2*k +: 2];
            if (code == CODE_ADD) begin
                sum4 = sum4 + 11'(a);
            end else if (code == CODE_SUB) begin
                sum4 = sum4 - 11'(a);
            end
        end
    end

    assign acc_sum = acc_reg + ACC_W'(sum4);

    // a later activation load wins over the row still in the second stage
    always_comb begin
        acc_next = acc_reg;
        if (is_act) begin
            acc_next = '0;
        end else if (s1_valid_reg) begin
            acc_next = s1_last_reg ? '0 : acc_sum;
        end
    end

    always_comb begin
        push.valid       = s1_valid_reg && s1_last_reg;
        push.entry.row   = s1_row_reg;
        push.entry.sum   = acc_sum;
        push.entry.scale = scale_reg[s1_gi_reg];
    end

    // counters and stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            acc_reg      <= acc_next;
            s1_valid_reg <= is_wt;
        end
    end

    // second stage payload, group index taken at the row end
    always_ff @(posedge aclk) begin
        if (is_wt) begin
            s1_last_reg <= row_done;
            s1_row_reg  <= row_reg;
            s1_gi_reg   <= group_index(row_reg, rows_per_group_reg, group_count_reg);
            s1_wts_reg  <= s_weights;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tim_queue.sv =====
`default_nettype none

module tim_queue
    import tim_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire push_t           push,
    input  wire logic            pop,
    output row_entry_t           head,
    output logic                 empty,
    output logic [QCW-1:0]       level
);

    row_entry_t       entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign level = count_reg;
    assign head  = entry_reg[rd_ptr_reg];

    // fill level
    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tim_back.sv =====
`default_nettype none

module tim_back
    import tim_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire row_entry_t        head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROW_W-1:0]       m_row,
    output logic [ACC_W-1:0]       m_sum,
    output logic [PROD_W-1:0]      m_scaled
);

    logic                     m_valid_reg;
    logic [ROW_W-1:0]         m_row_reg;
    logic [ACC_W-1:0]         m_sum_reg;
    logic [PROD_W-1:0]        m_scaled_reg;
    logic                     load_out;
    logic signed [MUL_W-1:0]  prod;

    // take the next row once the output register is free
    assign load_out = !m_valid_reg || m_ready;
    assign pop      = !empty && load_out;

    // scale multiply straight into the output register
    assign prod = head.sum * head.scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_row_reg    <= head.row;
            m_sum_reg    <= head.sum;
            m_scaled_reg <= prod[PROD_W-1:0];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_row    = m_row_reg;
    assign m_sum    = m_sum_reg;
    assign m_scaled = m_scaled_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ternary_int8_matvec_top.sv =====
`default_nettype none

// Ternary-weight int8 matrix-vector engine. Load the activation vector as
// 32-bit words of four int8 values (kind 0) and the per-group Q16.16 scales
// (kind 1), then stream weight bytes (kind 2), four 2-bit codes each, lowest
// first: 1 adds, 2 subtracts, 0 and 3 skip. After row_length/4 bytes one beat
// leaves with the row index, the integer sum and the sum times the scale of
// group min(row / rows-per-group register, group_count - 1). An activation
// load restarts the row and column counters. One item is taken every clock;
// input stalls only while the four-entry result queue, counting a row about
// to enter it, is full, which happens when the output side holds back. A
// result beat follows the last weight byte of its row through the second
// stage and the queue (sum into the queue, then multiply into the output
// register). The activation store is a 2048-word RAM with no reset and
// needs no clearing pass; only written words and scales may be used.
// Register writes take effect at once and belong between runs.

module ternary_int8_matvec_top
    import tim_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // register write port
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [13:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slot[10:0], act_0[18:11], act_1[26:19], act_2[34:27], act_3[42:35],
    // scale_value[74:43], packed_weights[82:75], zero fill up to 87
    input  wire logic [87:0]  s_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row_index[15:0], dot_sum[37:16], scaled_sum[90:38], zero fill up to 95
    output logic [95:0]       m_tdata
);

    push_t              push;
    row_entry_t         head;
    logic               q_empty;
    logic [QCW-1:0]     q_level;
    logic               q_pop;
    logic [ROW_W-1:0]   m_row;
    logic [ACC_W-1:0]   m_sum;
    logic [PROD_W-1:0]  m_scaled;

    // front: accept, count columns, accumulate
    tim_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_kind        (s_tuser),
        .s_slot        (s_tdata[10:0]),
        .s_acts        (s_tdata[42:11]),
        .s_scale_value (s_tdata[74:43]),
        .s_weights     (s_tdata[82:75]),
        .q_level       (q_level),
        .push          (push)
    );

    // finished rows
    tim_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty),
        .level   (q_level)
    );

    // back: scale multiply and output beat
    tim_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_row    (m_row),
        .m_sum    (m_sum),
        .m_scaled (m_scaled)
    );

    assign m_tdata = {5'b0, m_scaled, m_sum, m_row};

endmodule

`default_nettype wire
